// ===== sv/obb_pkg.sv =====
// Shared constants and types for the box pair overlap test.
`timescale 1ns / 1ps
package obb_pkg;

  localparam int unsigned LANE_W        = 16;
  localparam int unsigned PIECE_W       = 6;
  localparam int unsigned TEST_W        = 5;
  localparam int unsigned NUM_FLAGS     = 16;
  localparam int unsigned ROT_FRAC_BITS = 14;
  localparam int unsigned ACC_W         = 40;
  localparam int unsigned QUEUE_DEPTH   = 8;

  // Result codes
  localparam logic [TEST_W-1:0] TEST_SPHERE = 5'd0;
  localparam logic [TEST_W-1:0] TEST_NONE   = 5'd16;

  // One classified pair: bit 0 sphere reject, bit k separating axis k
  typedef struct packed {
    logic [NUM_FLAGS-1:0] fail;
    logic [PIECE_W-1:0]   piece_a;
    logic [PIECE_W-1:0]   piece_b;
  } q_entry_t;

endpackage

// ===== sv/obb_front.sv =====
// Front end: capture a box pair, form all lane products, evaluate every test.
`timescale 1ns / 1ps
module obb_front #(
  parameter int unsigned DEPTH = obb_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [47:0]          rel_center_i,
  input  logic [47:0]          rot_row0_i,
  input  logic [47:0]          rot_row1_i,
  input  logic [47:0]          rot_row2_i,
  input  logic [47:0]          size_a_i,
  input  logic [47:0]          size_b_i,
  input  logic [31:0]          radius_sq_sum_i,
  input  logic [5:0]           piece_a_i,
  input  logic [5:0]           piece_b_i,
  input  logic                 q_pop_i,
  output logic                 q_push_o,
  output obb_pkg::q_entry_t    q_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = obb_pkg::LANE_W;
  localparam int unsigned SH = obb_pkg::ROT_FRAC_BITS;
  localparam int unsigned AW = obb_pkg::ACC_W;

  logic                 accept;
  logic [CW-1:0]        cnt_d, cnt_q;
  logic                 v1_q, v2_q;
  logic [47:0]          rot_w [3];

  // Stage 1 registers
  logic signed [LW-1:0] t_q [3];
  logic signed [LW-1:0] r_q [3][3];
  logic [LW-1:0]        a_q [3];
  logic [LW-1:0]        b_q [3];
  logic [31:0]          rad_q;
  logic [5:0]           pa_q, pb_q;
  logic [LW:0]          ar [3][3];
  logic [LW:0]          abs_t [3];

  // Stage 2 registers
  logic signed [31:0]   tr_q [3][3][3];
  logic [32:0]          ap_q [3][3][3];
  logic [32:0]          bp_q [3][3][3];
  logic [31:0]          tt_q [3];
  logic [LW:0]          abs_t_q [3];
  logic [LW-1:0]        a2_q [3];
  logic [LW-1:0]        b2_q [3];
  logic [31:0]          rad2_q;
  logic [5:0]           pa2_q, pb2_q;

  logic [obb_pkg::NUM_FLAGS-1:0] fail;

  assign rot_w[0] = rot_row0_i;
  assign rot_w[1] = rot_row1_i;
  assign rot_w[2] = rot_row2_i;

  // Credits cover the pipeline and the queue, so the queue never overflows
  assign accept = push && !full;
  assign full   = (cnt_q == CW'(DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !q_pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!accept && q_pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
    end
  end

  // Capture the pair; rotation row word j, lane i holds R[i][j]
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= rel_center_i[LW*i +: LW];
        a_q[i] <= size_a_i[LW*i +: LW];
        b_q[i] <= size_b_i[LW*i +: LW];
        for (int j = 0; j < 3; j++) begin
          r_q[i][j] <= rot_w[j][LW*i +: LW];
        end
      end
      rad_q <= radius_sq_sum_i;
      pa_q  <= piece_a_i;
      pb_q  <= piece_b_i;
    end
  end

  // Magnitudes; the most negative lane maps to its full magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_t[i] = t_q[i][LW-1] ? (~{t_q[i][LW-1], t_q[i]} + 1'b1) : {1'b0, t_q[i]};
      for (int j = 0; j < 3; j++) begin
        ar[i][j] = r_q[i][j][LW-1] ? (~{r_q[i][j][LW-1], r_q[i][j]} + 1'b1)
                                   : {1'b0, r_q[i][j]};
      end
    end
  end

  // Form every lane product, one multiplier each
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int m = 0; m < 3; m++) begin
        tt_q[m]    <= 32'(t_q[m] * t_q[m]);
        abs_t_q[m] <= abs_t[m];
        a2_q[m]    <= a_q[m];
        b2_q[m]    <= b_q[m];
        for (int n = 0; n < 3; n++) begin
          for (int j = 0; j < 3; j++) begin
            tr_q[m][n][j] <= 32'(t_q[m] * r_q[n][j]);
            ap_q[m][n][j] <= 33'(a_q[m]) * 33'(ar[n][j]);
            bp_q[m][n][j] <= 33'(b_q[m]) * 33'(ar[n][j]);
          end
        end
      end
      rad2_q <= rad_q;
      pa2_q  <= pa_q;
      pb2_q  <= pb_q;
    end
  end

  // Evaluate the sphere test and all fifteen axes; sizes align to the rotation point
  always_comb begin
    logic [33:0]         d2;
    logic signed [AW-1:0] lhs, rhs, s;
    int i1, i2, j1, j2;
    fail = '0;
    d2 = 34'(tt_q[0]) + 34'(tt_q[1]) + 34'(tt_q[2]);
    fail[0] = d2 > {2'b00, rad2_q};
    for (int i = 0; i < 3; i++) begin
      lhs = AW'({abs_t_q[i], {(SH + 1){1'b0}}});
      rhs = AW'({a2_q[i], {SH{1'b0}}}) + AW'(bp_q[0][i][0]) + AW'(bp_q[1][i][1])
          + AW'(bp_q[2][i][2]);
      fail[1+i] = lhs > rhs;
    end
    for (int j = 0; j < 3; j++) begin
      s   = AW'(tr_q[0][0][j]) + AW'(tr_q[1][1][j]) + AW'(tr_q[2][2][j]);
      lhs = (s < 0) ? -s : s;
      lhs = lhs <<< 1;
      rhs = AW'({b2_q[j], {SH{1'b0}}}) + AW'(ap_q[0][0][j]) + AW'(ap_q[1][1][j])
          + AW'(ap_q[2][2][j]);
      fail[4+j] = lhs > rhs;
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        s   = AW'(tr_q[i2][i1][j]) - AW'(tr_q[i1][i2][j]);
        lhs = (s < 0) ? -s : s;
        lhs = lhs <<< 1;
        rhs = AW'(ap_q[i1][i2][j]) + AW'(ap_q[i2][i1][j]) + AW'(bp_q[j1][i][j2])
            + AW'(bp_q[j2][i][j1]);
        fail[7+3*i+j] = lhs > rhs;
      end
    end
  end

  assign q_push_o         = v2_q;
  assign q_data_o.fail    = fail;
  assign q_data_o.piece_a = pa2_q;
  assign q_data_o.piece_b = pb2_q;

endmodule

// ===== sv/obb_queue.sv =====
// Short queue of classified pairs between the front and back ends.
`timescale 1ns / 1ps
module obb_queue #(
  parameter int unsigned DEPTH = obb_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  obb_pkg::q_entry_t wdata_i,
  input  logic              pop_i,
  output obb_pkg::q_entry_t rdata_o,
  output logic              empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  obb_pkg::q_entry_t mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [CW-1:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== sv/obb_back.sv =====
// Back end: pick the first failing test and hold the result for transfer.
`timescale 1ns / 1ps
module obb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obb_pkg::q_entry_t q_data_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic              overlap_o,
  output logic [4:0]        first_failing_test_o,
  output logic [5:0]        piece_a_out_o,
  output logic [5:0]        piece_b_out_o
);

  logic        out_v_q;
  logic        load;
  logic [4:0]  code;

  // Lowest set flag wins
  always_comb begin
    code = obb_pkg::TEST_NONE;
    for (int k = obb_pkg::NUM_FLAGS - 1; k >= 0; k--) begin
      if (q_data_i.fail[k]) begin
        code = 5'(k);
      end
    end
  end

  assign load    = !q_empty_i && (!out_v_q || pop);
  assign q_pop_o = load;
  assign empty   = !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  // Hold result until transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      first_failing_test_o <= code;
      overlap_o            <= (code == obb_pkg::TEST_NONE);
      piece_a_out_o        <= q_data_i.piece_a;
      piece_b_out_o        <= q_data_i.piece_b;
    end
  end

endmodule

// ===== sv/obb_pair_overlap_test_core.sv =====
// Top level of the oriented box pair overlap test.
//
// Input channel: push / full. One box pair (expressed in box A's frame)
// transfers at a clock edge with push high and full low.
// Result channel: empty / pop. The oldest result sits on the result ports
// while empty is low and transfers at an edge with pop high.
// Each pair yields one result: overlap flag, first failing test (0 sphere
// reject, 1..15 separating axis, 16 none) and the echoed piece indices.
// When the result side is idle, an accepted pair passes through the capture
// registers, the product registers, the queue (tests evaluated on the way in)
// and the output register before its result is visible. Throughput: one pair
// per cycle while full is low, set by the fully pipelined product and compare
// stages; the pipeline and the QUEUE_DEPTH-entry queue share QUEUE_DEPTH credits.
// Reset empties the pipeline, queue and output register; full and empty
// come out of reset low and high.
// When the receiver stalls, results collect in the queue; full rises once
// QUEUE_DEPTH pairs are in flight and drops as soon as one is taken.
`timescale 1ns / 1ps
module obb_pair_overlap_test_core #(
  parameter int unsigned QUEUE_DEPTH = obb_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [47:0] rel_center_i,
  input  logic [47:0] rot_row0_i,
  input  logic [47:0] rot_row1_i,
  input  logic [47:0] rot_row2_i,
  input  logic [47:0] size_a_i,
  input  logic [47:0] size_b_i,
  input  logic [31:0] radius_sq_sum_i,
  input  logic [5:0]  piece_a_i,
  input  logic [5:0]  piece_b_i,
  output logic        empty,
  input  logic        pop,
  output logic        overlap_o,
  output logic [4:0]  first_failing_test_o,
  output logic [5:0]  piece_a_out_o,
  output logic [5:0]  piece_b_out_o
);

  logic              q_push, q_pop, q_empty;
  obb_pkg::q_entry_t q_wdata, q_rdata;

  obb_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .rel_center_i, .rot_row0_i, .rot_row1_i, .rot_row2_i,
    .size_a_i, .size_b_i, .radius_sq_sum_i, .piece_a_i, .piece_b_i,
    .q_pop_i  (q_pop),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  obb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  obb_back u_back (
    .clk_i, .rst_ni,
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop, .empty,
    .overlap_o, .first_failing_test_o, .piece_a_out_o, .piece_b_out_o
  );

endmodule

// ===== sv/obb_checker.sv =====
// Port-level checks for the box pair overlap test, bound to the top level.
`timescale 1ns / 1ps
module obb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       overlap_o,
  input logic [4:0] first_failing_test_o,
  input logic [5:0] piece_a_out_o,
  input logic [5:0] piece_b_out_o
);

  // Overlap flag agrees with the test code
  a_overlap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (overlap_o == (first_failing_test_o == obb_pkg::TEST_NONE)))
    else $error("overlap flag disagrees with failing test code");

  // Test code stays within its range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (first_failing_test_o <= obb_pkg::TEST_NONE))
    else $error("failing test code out of range");

  // A waiting result holds until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(first_failing_test_o)
      && $stable(piece_a_out_o) && $stable(piece_b_out_o)))
    else $error("result changed while stalled");

endmodule

bind obb_pair_overlap_test_core obb_checker u_obb_checker (.*);

// ===== verif/obb_overlap_checker.sv =====
// Checker for the box pair overlap test: predicts each result and compares it.
`timescale 1ns / 1ps
module obb_overlap_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [47:0] rel_center_i,
  input  logic [47:0] rot_row0_i,
  input  logic [47:0] rot_row1_i,
  input  logic [47:0] rot_row2_i,
  input  logic [47:0] size_a_i,
  input  logic [47:0] size_b_i,
  input  logic [31:0] radius_sq_sum_i,
  input  logic [5:0]  piece_a_i,
  input  logic [5:0]  piece_b_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        overlap_o,
  input  logic [4:0]  first_failing_test_o,
  input  logic [5:0]  piece_a_out_o,
  input  logic [5:0]  piece_b_out_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          verdict_hist_o [0:16]
);

  typedef struct {
    logic       overlap;
    logic [4:0] test;
    logic [5:0] pa;
    logic [5:0] pb;
  } verdict_t;

  verdict_t verdict_q[$];

  function automatic longint slane(logic [47:0] w, int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  function automatic longint ulane(logic [47:0] w, int k);
    return longint'({1'b0, w[16*k +: 16]});
  endfunction

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Sphere reject, then the 15 separating axes in classic order
  function automatic logic [4:0] classify_pair(logic [47:0] tc, logic [47:0] r0,
      logic [47:0] r1, logic [47:0] r2, logic [47:0] sa, logic [47:0] sb,
      logic [31:0] rsq);
    longint t[3], a[3], b[3], r[3][3], ar[3][3];
    longint unit, lhs, rhs, dist2;
    logic [47:0] rows[3];
    int i1, i2, j1, j2, k;
    unit = longint'(1) << obb_pkg::ROT_FRAC_BITS;
    rows[0] = r0; rows[1] = r1; rows[2] = r2;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = slane(tc, i);
      a[i] = ulane(sa, i);
      b[i] = ulane(sb, i);
      dist2 += t[i] * t[i];
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        k = 3 * j + i;
        r[i][j] = slane(rows[k / 3], k % 3);
        ar[i][j] = absv(r[i][j]);
      end
    if (dist2 > longint'({1'b0, rsq})) return obb_pkg::TEST_SPHERE;
    for (int i = 0; i < 3; i++) begin
      lhs = 2 * absv(t[i]) * unit;
      rhs = a[i] * unit + b[0] * ar[i][0] + b[1] * ar[i][1] + b[2] * ar[i][2];
      if (lhs > rhs) return 5'(1 + i);
    end
    for (int j = 0; j < 3; j++) begin
      lhs = t[0] * r[0][j] + t[1] * r[1][j] + t[2] * r[2][j];
      rhs = b[j] * unit + a[0] * ar[0][j] + a[1] * ar[1][j] + a[2] * ar[2][j];
      if (2 * absv(lhs) > rhs) return 5'(4 + j);
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3; i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        lhs = t[i2] * r[i1][j] - t[i1] * r[i2][j];
        rhs = a[i1] * ar[i2][j] + a[i2] * ar[i1][j] + b[j1] * ar[i][j2] + b[j2] * ar[i][j1];
        if (2 * absv(lhs) > rhs) return 5'(7 + 3 * i + j);
      end
    end
    return obb_pkg::TEST_NONE;
  endfunction

  initial begin
    fail_count_o = 0;
    foreach (verdict_hist_o[i]) verdict_hist_o[i] = 0;
  end
  assign pending_o = verdict_q.size();

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      // Predict on every input transfer
      if (push && !full) begin
        exp_v.test = classify_pair(rel_center_i, rot_row0_i, rot_row1_i, rot_row2_i,
                                   size_a_i, size_b_i, radius_sq_sum_i);
        exp_v.overlap = (exp_v.test == obb_pkg::TEST_NONE);
        exp_v.pa = piece_a_i;
        exp_v.pb = piece_b_i;
        verdict_q.push_back(exp_v);
        verdict_hist_o[exp_v.test] = verdict_hist_o[exp_v.test] + 1;
      end
      // Compare on every result transfer
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_v = verdict_q.pop_front();
          if (overlap_o !== exp_v.overlap) begin
            $error("overlap: expected %0d, got %0d", exp_v.overlap, overlap_o);
            fail_count_o = fail_count_o + 1;
          end
          if (first_failing_test_o !== exp_v.test) begin
            $error("first_failing_test: expected %0d, got %0d", exp_v.test,
                   first_failing_test_o);
            fail_count_o = fail_count_o + 1;
          end
          if (piece_a_out_o !== exp_v.pa) begin
            $error("piece_a_out: expected %0d, got %0d", exp_v.pa, piece_a_out_o);
            fail_count_o = fail_count_o + 1;
          end
          if (piece_b_out_o !== exp_v.pb) begin
            $error("piece_b_out: expected %0d, got %0d", exp_v.pb, piece_b_out_o);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the box pair overlap test: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int NUM_RANDOM = 1600;
  localparam int NUM_DIRECTED = 21;
  localparam int STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [47:0] rel_center_i = '0, rot_row0_i = '0, rot_row1_i = '0, rot_row2_i = '0;
  logic [47:0] size_a_i = '0, size_b_i = '0;
  logic [31:0] radius_sq_sum_i = '0;
  logic [5:0]  piece_a_i = '0, piece_b_i = '0;
  logic        overlap_o;
  logic [4:0]  first_failing_test_o;
  logic [5:0]  piece_a_out_o, piece_b_out_o;
  int          fail_count, pending, idle_cycles;
  int          verdict_hist [0:16];
  bit          burst_mode = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  obb_pair_overlap_test_core dut (
    .clk_i, .rst_ni, .push, .full, .rel_center_i, .rot_row0_i, .rot_row1_i,
    .rot_row2_i, .size_a_i, .size_b_i, .radius_sq_sum_i, .piece_a_i, .piece_b_i,
    .empty, .pop, .overlap_o, .first_failing_test_o, .piece_a_out_o, .piece_b_out_o
  );

  obb_overlap_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .rel_center_i, .rot_row0_i, .rot_row1_i,
    .rot_row2_i, .size_a_i, .size_b_i, .radius_sq_sum_i, .piece_a_i, .piece_b_i,
    .empty, .pop, .overlap_o, .first_failing_test_o, .piece_a_out_o, .piece_b_out_o,
    .fail_count_o(fail_count), .pending_o(pending), .verdict_hist_o(verdict_hist)
  );

  function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  // Rotation lane near a unit rotation: mostly cos/sin-like, sometimes wild
  function automatic logic [15:0] rand_rot_lane(bit wild);
    if (wild) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // Drive one pair, hold it until it transfers; push stays high for the next one
  task automatic send_pair(logic [47:0] tc, logic [47:0] r0, logic [47:0] r1,
      logic [47:0] r2, logic [47:0] sa, logic [47:0] sb, logic [31:0] rsq,
      logic [5:0] pa, logic [5:0] pb);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rel_center_i <= tc; rot_row0_i <= r0; rot_row1_i <= r1; rot_row2_i <= r2;
    size_a_i <= sa; size_b_i <= sb; radius_sq_sum_i <= rsq;
    piece_a_i <= pa; piece_b_i <= pb;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Random pair: mostly plausible geometry with a generous radius bound
  task automatic send_random_pair();
    logic [15:0] tl[3], sl[6], rl[9];
    logic [31:0] rsq;
    bit wild;
    wild = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 3; i++)
      tl[i] = wild ? 16'($urandom) : 16'($urandom_range(0, 2048) - 1024);
    for (int i = 0; i < 6; i++)
      sl[i] = wild ? 16'($urandom) : 16'($urandom_range(64, 1024));
    for (int i = 0; i < 9; i++) rl[i] = rand_rot_lane(wild);
    case ($urandom_range(0, 3))
      0: rsq = $urandom;
      1: rsq = 32'hFFFF_FFFF;
      default: rsq = $urandom_range(0, 32'h0300_0000);
    endcase
    send_pair(pack3(tl[0], tl[1], tl[2]), pack3(rl[0], rl[1], rl[2]),
              pack3(rl[3], rl[4], rl[5]), pack3(rl[6], rl[7], rl[8]),
              pack3(sl[0], sl[1], sl[2]), pack3(sl[3], sl[4], sl[5]),
              rsq, 6'($urandom), 6'($urandom));
  endtask

  // Receiver: random stall per result, with stall-free stretches
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (burst_mode) wait_n = 0;
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("obb_pair_overlap_test_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [15:0] unit;
    unit = 16'h4000;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity rotation, touching boxes: equality does not separate
    send_pair(pack3(16'h0200, 16'h0, 16'h0), pack3(unit, 16'h0, 16'h0),
              pack3(16'h0, unit, 16'h0), pack3(16'h0, 16'h0, unit),
              pack3(16'h0200, 16'h0200, 16'h0200), pack3(16'h0200, 16'h0200, 16'h0200),
              32'h0004_0000, 6'd0, 6'd63);
    // Just past touching along each A axis
    for (int i = 0; i < 3; i++)
      send_pair(48'(17'h0201) << (16 * i), pack3(unit, 16'h0, 16'h0),
                pack3(16'h0, unit, 16'h0), pack3(16'h0, 16'h0, unit),
                pack3(16'h0200, 16'h0200, 16'h0200),
                pack3(16'h0200, 16'h0200, 16'h0200), 32'hFFFF_FFFF, 6'(i), 6'(i));
    // Sphere test: equality passes, one more rejects
    send_pair(pack3(16'h0100, 16'h0, 16'h0), '0, '0, '0, '0, '0, 32'h0001_0000,
              6'd1, 6'd2);
    send_pair(pack3(16'h0100, 16'h0, 16'h0), '0, '0, '0, '0, '0, 32'h0000_FFFF,
              6'd3, 6'd4);
    // Lane extremes, including the -2.0 rotation lane
    send_pair({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
              {3{16'hFFFF}}, {3{16'hFFFF}}, 32'hFFFF_FFFF, 6'd63, 6'd0);
    send_pair({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
              '0, '0, 32'hFFFF_FFFF, 6'd32, 6'd31);
    send_pair({3{16'hFFFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8001}},
              {3{16'hFFFF}}, '0, 32'hFFFF_FFFF, 6'd21, 6'd42);
    send_pair('0, '0, '0, '0, '0, '0, '0, 6'd0, 6'd0);
    send_pair({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
              {48{1'b1}}, 32'hFFFF_FFFF, 6'd63, 6'd63);
    // Rotated B (90 deg about z), thin boxes: separation on B axes and edges
    for (int k = 0; k < 10; k++)
      send_pair(pack3(16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 1024) - 512),
                      16'($urandom_range(0, 1024) - 512)),
                pack3(16'h0000, 16'hC000, 16'h0), pack3(unit, 16'h0, 16'h0),
                pack3(16'h0, 16'h0, unit),
                pack3(16'h0040, 16'h0400, 16'h0010), pack3(16'h0400, 16'h0020, 16'h0200),
                32'hFFFF_FFFF, 6'(k), 6'(63 - k));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Drain once mid-run, then push a back-to-back burst
      if (n == NUM_RANDOM / 2) begin
        push <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
        burst_mode = 1'b1;
      end
      if (n == NUM_RANDOM / 2 + 60) burst_mode = 1'b0;
      send_random_pair();
    end
    push <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d pairs: sphere rejects %0d, overlaps %0d",
             NUM_RANDOM + NUM_DIRECTED, verdict_hist[0], verdict_hist[16]);
    for (int k = 1; k < 16; k++)
      if (verdict_hist[k] == 0) $display("note: axis %0d never separated a pair", k);
    if (fail_count == 0) $display("obb_pair_overlap_test_core: match");
    else $display("obb_pair_overlap_test_core: mismatch");
    $finish;
  end
endmodule
